// File: design/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg
// Types, constants and helper functions shared by the screen fade
// brightness controller and its step divider.
// ----------------------------------------------------------------------------
package sfb_pkg;

  localparam int LevelW = 10;
  localparam int StepW  = 9;
  localparam int TicksW = 8;
  localparam int CodeW  = 16;
  localparam int InLvlW = 6;
  localparam int CountW = 4;

  typedef logic signed [LevelW-1:0] level_t;
  typedef logic [StepW-1:0]         step_t;
  typedef logic [TicksW-1:0]        ticks_t;
  typedef logic [CodeW-1:0]         code_t;
  typedef logic signed [InLvlW-1:0] shade_t;

  localparam level_t LevelMin  = -10'sd256;
  localparam level_t LevelMax  = 10'sd256;
  localparam step_t  StepReset = 9'd32;
  localparam ticks_t TicksMax  = 8'd128;
  localparam code_t  CodeUp    = 16'h4000;
  localparam code_t  CodeDown  = 16'h8000;
  localparam step_t  Dividend  = 9'h100;
  localparam shade_t ShadeBlack = -6'sd16;
  localparam shade_t ShadeWhite = 6'sd16;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_FADE_IN   = 3'd1,
    CMD_TO_BLACK  = 3'd2,
    CMD_TO_WHITE  = 3'd3,
    CMD_BLACK_OUT = 3'd4,
    CMD_WHITE_OUT = 3'd5,
    CMD_RESET     = 3'd6,
    CMD_SET_LEVEL = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_FROM_BLACK = 3'd1,
    KIND_TO_BLACK   = 3'd2,
    KIND_FROM_WHITE = 3'd3,
    KIND_TO_WHITE   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_EXEC,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic   start;
    ticks_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    step_t quotient;
  } div_rsp_t;

  function automatic shade_t div16(input level_t v);
    logic [LevelW:0] mag;
    logic [InLvlW-1:0] n;
    mag = v[LevelW-1] ? (~{v[LevelW-1], v} + 11'd1) : {v[LevelW-1], v};
    n = InLvlW'(mag >> 4);
    return v[LevelW-1] ? $signed(~n + 6'd1) : $signed(n);
  endfunction

  function automatic code_t code_of(input shade_t n);
    logic [InLvlW-1:0] mag;
    code_t res;
    mag = n[InLvlW-1] ? (~n + 6'd1) : n;
    if (n == 6'sd0) begin
      res = '0;
    end else if (n[InLvlW-1]) begin
      res = CodeDown | {{(CodeW-InLvlW){1'b0}}, mag};
    end else begin
      res = CodeUp | {{(CodeW-InLvlW){1'b0}}, mag};
    end
    return res;
  endfunction

  function automatic ticks_t clamp_ticks(input ticks_t t);
    ticks_t res;
    if (t == '0) begin
      res = 8'd1;
    end else if (t > TicksMax) begin
      res = TicksMax;
    end else begin
      res = t;
    end
    return res;
  endfunction

endpackage

// File: design/sfb_divider.sv
// ----------------------------------------------------------------------------
// sfb_divider
// Restoring serial divider: 256 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfb_divider (
  input  logic              clk,
  input  logic              rst,
  input  sfb_pkg::div_req_t req,
  output sfb_pkg::div_rsp_t rsp
);
  import sfb_pkg::*;

  localparam logic [CountW-1:0] LastCount = CountW'(StepW - 1);

  logic              busy;
  logic              done;
  logic [CountW-1:0] count;
  ticks_t            divisor;
  ticks_t            rem;
  ticks_t            rem_next;
  step_t             quo;
  logic [StepW-1:0]  shifted;
  logic              qbit;

  always_comb begin
    shifted  = {rem, Dividend[count]};
    qbit     = shifted >= {1'b0, divisor};
    rem_next = qbit ? TicksW'(shifted - {1'b0, divisor}) : shifted[TicksW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        count   <= LastCount;
        rem     <= '0;
        quo     <= '0;
        divisor <= req.divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[StepW-2:0], qbit};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: design/screen_fade_brightness_controller.sv
// ----------------------------------------------------------------------------
// screen_fade_brightness_controller
// Two-screen brightness fade controller with per-screen fade state and
// master brightness codes.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result showing both screens.
// Tick, black out, white out, reset and set level pass through the load,
// execute and hold states, and hold waits while the result is stalled. Fade
// in, to black and to white also wait in a divide state: the step 256/ticks
// comes from a serial divider that produces one quotient bit per cycle.
module screen_fade_brightness_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            command,
  input  logic                  screen,
  input  logic [7:0]            fade_ticks,
  input  logic signed [5:0]     level,
  input  logic                  request_update,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           main_bright_code,
  output logic [15:0]           sub_bright_code,
  output logic                  main_fading,
  output logic                  sub_fading,
  output logic                  main_adjusted,
  output logic                  sub_adjusted,
  output logic                  update_requested
);
  import sfb_pkg::*;

  state_t   state;
  state_t   state_next;
  cmd_t     cmd;
  logic     scr;
  ticks_t   ticks;
  shade_t   shade;
  logic     req_upd;

  level_t   fade_level [2];
  kind_t    fade_kind [2];
  step_t    fade_step [2];
  logic     start_delay [2];
  code_t    bright_code [2];
  logic     update_flag;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     accept;
  logic     is_fade;
  logic     exec_en;

  level_t   lvl_next;
  kind_t    kind_next;
  step_t    step_next;
  logic     delay_next;
  code_t    code_next;
  logic     flag_next;
  logic signed [LevelW:0] sum;
  level_t   tick_lvl;
  kind_t    tick_kind;

  assign accept  = in_valid && !in_stall;
  assign is_fade = (cmd == CMD_FADE_IN) || (cmd == CMD_TO_BLACK) || (cmd == CMD_TO_WHITE);

  sfb_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_LOAD;
      ST_LOAD:   state_next = is_fade ? ST_DIVIDE : ST_EXEC;
      ST_DIVIDE: if (div_rsp.done) state_next = ST_EXEC;
      ST_EXEC:   state_next = ST_HOLD;
      ST_HOLD:   if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = state != ST_IDLE;
    out_valid       = state == ST_HOLD;
    exec_en         = state == ST_EXEC;
    div_req.start   = (state == ST_LOAD) && is_fade;
    div_req.divisor = clamp_ticks(ticks);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd <= CMD_TICK;
      scr <= 1'b0;
    end else if (accept) begin
      cmd     <= cmd_t'(command);
      scr     <= screen;
      ticks   <= fade_ticks;
      shade   <= level;
      req_upd <= request_update;
    end
  end

  always_comb begin
    sum       = {fade_level[scr][LevelW-1], fade_level[scr]};
    tick_lvl  = fade_level[scr];
    tick_kind = fade_kind[scr];
    unique case (fade_kind[scr])
      KIND_FROM_BLACK: begin
        sum = {fade_level[scr][LevelW-1], fade_level[scr]} + {2'b00, fade_step[scr]};
        if (sum > 11'sd0) begin
          tick_lvl  = '0;
          tick_kind = KIND_NONE;
        end else begin
          tick_lvl = LevelW'(sum);
        end
      end
      KIND_TO_BLACK: begin
        sum = {fade_level[scr][LevelW-1], fade_level[scr]} - {2'b00, fade_step[scr]};
        if (sum < -11'sd256) begin
          tick_lvl  = LevelMin;
          tick_kind = KIND_NONE;
        end else begin
          tick_lvl = LevelW'(sum);
        end
      end
      KIND_FROM_WHITE: begin
        sum = {fade_level[scr][LevelW-1], fade_level[scr]} - {2'b00, fade_step[scr]};
        if (sum < 11'sd0) begin
          tick_lvl  = '0;
          tick_kind = KIND_NONE;
        end else begin
          tick_lvl = LevelW'(sum);
        end
      end
      KIND_TO_WHITE: begin
        sum = {fade_level[scr][LevelW-1], fade_level[scr]} + {2'b00, fade_step[scr]};
        if (sum > 11'sd256) begin
          tick_lvl  = LevelMax;
          tick_kind = KIND_NONE;
        end else begin
          tick_lvl = LevelW'(sum);
        end
      end
      default: begin
        tick_lvl  = fade_level[scr];
        tick_kind = fade_kind[scr];
      end
    endcase
  end

  always_comb begin
    lvl_next   = fade_level[scr];
    kind_next  = fade_kind[scr];
    step_next  = fade_step[scr];
    delay_next = start_delay[scr];
    code_next  = bright_code[scr];
    flag_next  = update_flag;
    unique case (cmd)
      CMD_TICK: begin
        if (start_delay[scr]) begin
          delay_next = 1'b0;
        end else begin
          lvl_next  = tick_lvl;
          kind_next = tick_kind;
          if (div16(fade_level[scr]) != div16(tick_lvl)) begin
            code_next = code_of(div16(tick_lvl));
          end
        end
      end
      CMD_FADE_IN: begin
        if (fade_level[scr] < 10'sd0) begin
          kind_next = KIND_FROM_BLACK;
        end else if (fade_level[scr] > 10'sd0) begin
          kind_next = KIND_FROM_WHITE;
        end else begin
          kind_next = KIND_NONE;
        end
        step_next  = div_rsp.quotient;
        delay_next = 1'b1;
      end
      CMD_TO_BLACK: begin
        kind_next  = (fade_level[scr] > LevelMin) ? KIND_TO_BLACK : KIND_NONE;
        step_next  = div_rsp.quotient;
        delay_next = 1'b0;
      end
      CMD_TO_WHITE: begin
        kind_next  = (fade_level[scr] < LevelMax) ? KIND_TO_WHITE : KIND_NONE;
        step_next  = div_rsp.quotient;
        delay_next = 1'b0;
      end
      CMD_BLACK_OUT: begin
        lvl_next   = LevelMin;
        kind_next  = KIND_NONE;
        delay_next = 1'b0;
        code_next  = code_of(ShadeBlack);
      end
      CMD_WHITE_OUT: begin
        lvl_next   = LevelMax;
        kind_next  = KIND_NONE;
        delay_next = 1'b0;
        code_next  = code_of(ShadeWhite);
      end
      CMD_RESET: begin
        lvl_next   = '0;
        kind_next  = KIND_NONE;
        step_next  = StepReset;
        delay_next = 1'b0;
        code_next  = '0;
        flag_next  = 1'b1;
      end
      CMD_SET_LEVEL: begin
        code_next = code_of(shade);
        if (req_upd) flag_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        fade_level[i]  <= '0;
        fade_kind[i]   <= KIND_NONE;
        fade_step[i]   <= StepReset;
        start_delay[i] <= 1'b0;
        bright_code[i] <= '0;
      end
      update_flag <= 1'b0;
    end else if (exec_en) begin
      fade_level[scr]  <= lvl_next;
      fade_kind[scr]   <= kind_next;
      fade_step[scr]   <= step_next;
      start_delay[scr] <= delay_next;
      bright_code[scr] <= code_next;
      update_flag      <= flag_next;
    end
  end

  assign main_bright_code = bright_code[0];
  assign sub_bright_code  = bright_code[1];
  assign main_fading      = fade_kind[0] != KIND_NONE;
  assign sub_fading       = fade_kind[1] != KIND_NONE;
  assign main_adjusted    = fade_level[0] != '0;
  assign sub_adjusted     = fade_level[1] != '0;
  assign update_requested = update_flag;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the screen fade brightness controller. A short
// scripted run covers both screens, every command and the clamp and delay
// corners; random fade sequences with tick bursts follow, under changing
// sender and receiver idling. Every result is compared field by field with
// the typed script values or a software copy of both screens' fade state.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfb_pkg::*;

  typedef struct packed {
    cmd_t   cmd;
    logic   scr;
    ticks_t ticks;
    shade_t lvl;
    logic   upd;
  } fade_req_t;

  typedef struct packed {
    code_t main_code;
    code_t sub_code;
    logic  main_fade;
    logic  sub_fade;
    logic  main_adj;
    logic  sub_adj;
    logic  upd;
  } shade_report_t;

  typedef struct packed {
    fade_req_t     req;
    logic          typed;
    shade_report_t want;
  } script_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  command;
  logic        screen;
  logic [7:0]  fade_ticks;
  logic signed [5:0] level;
  logic        request_update;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] main_bright_code;
  logic [15:0] sub_bright_code;
  logic        main_fading;
  logic        sub_fading;
  logic        main_adjusted;
  logic        sub_adjusted;
  logic        update_requested;

  screen_fade_brightness_controller dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .screen           (screen),
    .fade_ticks       (fade_ticks),
    .level            (level),
    .request_update   (request_update),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .main_bright_code (main_bright_code),
    .sub_bright_code  (sub_bright_code),
    .main_fading      (main_fading),
    .sub_fading       (sub_fading),
    .main_adjusted    (main_adjusted),
    .sub_adjusted     (sub_adjusted),
    .update_requested (update_requested)
  );

  // predicted fade state of both screens
  level_t fade_lvl [2];
  kind_t  fade_kind [2];
  step_t  fade_step [2];
  logic   tick_hold [2];
  code_t  scr_code [2];
  logic   upd_flag;

  shade_report_t pending_reports [$];
  int errors = 0;
  int send_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;

  localparam int SendPct [4]  = '{0, 54, 0, 26};
  localparam int StallPct [4] = '{0, 0, 54, 26};

  script_row_t script [26] = '{
    '{'{CMD_TICK, 1'b0, 8'd0, 6'sd0, 1'b0}, 1'b1,
      '{16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_SET_LEVEL, 1'b0, 8'd0, 6'h20, 1'b0}, 1'b1,
      '{16'h8020, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_SET_LEVEL, 1'b1, 8'd0, 6'sd31, 1'b1}, 1'b1,
      '{16'h8020, 16'h401f, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_BLACK_OUT, 1'b0, 8'd5, 6'sd0, 1'b0}, 1'b1,
      '{16'h8010, 16'h401f, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{'{CMD_WHITE_OUT, 1'b1, 8'd5, 6'sd0, 1'b0}, 1'b1,
      '{16'h8010, 16'h4010, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{'{CMD_FADE_IN, 1'b0, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TICK, 1'b0, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TICK, 1'b0, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TO_BLACK, 1'b1, 8'd255, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TICK, 1'b1, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TO_WHITE, 1'b0, 8'd200, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TICK, 1'b0, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_RESET, 1'b0, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TO_BLACK, 1'b0, 8'd1, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TICK, 1'b0, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TO_BLACK, 1'b0, 8'd9, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TO_WHITE, 1'b1, 8'd3, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TICK, 1'b1, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TO_WHITE, 1'b1, 8'd128, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_FADE_IN, 1'b1, 8'd7, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TICK, 1'b1, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TICK, 1'b1, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_RESET, 1'b1, 8'd0, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_FADE_IN, 1'b1, 8'd129, 6'sd0, 1'b0}, 1'b0, '0},
    '{'{CMD_SET_LEVEL, 1'b0, 8'd0, 6'sd16, 1'b0}, 1'b0, '0},
    '{'{CMD_SET_LEVEL, 1'b1, 8'd0, -6'sd16, 1'b1}, 1'b0, '0}
  };

  function automatic code_t shade_code(input int n);
    if (n == 0) return '0;
    if (n > 0) return CodeUp | code_t'(n);
    return CodeDown | code_t'(-n);
  endfunction

  function automatic step_t step_for_ticks(input ticks_t t);
    int d;
    d = (t == 0) ? 1 : ((t > TicksMax) ? int'(TicksMax) : int'(t));
    return step_t'(256 / d);
  endfunction

  function automatic void advance_fade(input int s);
    int was;
    int now_lvl;
    int stp;
    was = int'(fade_lvl[s]);
    now_lvl = was;
    stp = int'(fade_step[s]);
    if (tick_hold[s]) begin
      tick_hold[s] = 1'b0;
      return;
    end
    case (fade_kind[s])
      KIND_FROM_BLACK: begin
        now_lvl = was + stp;
        if (now_lvl > 0) begin
          now_lvl = 0;
          fade_kind[s] = KIND_NONE;
        end
      end
      KIND_TO_BLACK: begin
        now_lvl = was - stp;
        if (now_lvl < int'(LevelMin)) begin
          now_lvl = int'(LevelMin);
          fade_kind[s] = KIND_NONE;
        end
      end
      KIND_FROM_WHITE: begin
        now_lvl = was - stp;
        if (now_lvl < 0) begin
          now_lvl = 0;
          fade_kind[s] = KIND_NONE;
        end
      end
      KIND_TO_WHITE: begin
        now_lvl = was + stp;
        if (now_lvl > int'(LevelMax)) begin
          now_lvl = int'(LevelMax);
          fade_kind[s] = KIND_NONE;
        end
      end
      default: ;
    endcase
    if (was / 16 != now_lvl / 16) scr_code[s] = shade_code(now_lvl / 16);
    fade_lvl[s] = level_t'(now_lvl);
  endfunction

  function automatic shade_report_t apply_command(input fade_req_t r);
    shade_report_t rep;
    int s;
    s = int'(r.scr);
    case (r.cmd)
      CMD_TICK: advance_fade(s);
      CMD_FADE_IN: begin
        if (fade_lvl[s] < 0) fade_kind[s] = KIND_FROM_BLACK;
        else if (fade_lvl[s] > 0) fade_kind[s] = KIND_FROM_WHITE;
        else fade_kind[s] = KIND_NONE;
        fade_step[s] = step_for_ticks(r.ticks);
        tick_hold[s] = 1'b1;
      end
      CMD_TO_BLACK: begin
        fade_kind[s] = (fade_lvl[s] > LevelMin) ? KIND_TO_BLACK : KIND_NONE;
        fade_step[s] = step_for_ticks(r.ticks);
        tick_hold[s] = 1'b0;
      end
      CMD_TO_WHITE: begin
        fade_kind[s] = (fade_lvl[s] < LevelMax) ? KIND_TO_WHITE : KIND_NONE;
        fade_step[s] = step_for_ticks(r.ticks);
        tick_hold[s] = 1'b0;
      end
      CMD_BLACK_OUT: begin
        fade_lvl[s] = LevelMin;
        fade_kind[s] = KIND_NONE;
        tick_hold[s] = 1'b0;
        scr_code[s] = shade_code(-16);
      end
      CMD_WHITE_OUT: begin
        fade_lvl[s] = LevelMax;
        fade_kind[s] = KIND_NONE;
        tick_hold[s] = 1'b0;
        scr_code[s] = shade_code(16);
      end
      CMD_RESET: begin
        fade_lvl[s] = '0;
        fade_kind[s] = KIND_NONE;
        fade_step[s] = StepReset;
        tick_hold[s] = 1'b0;
        scr_code[s] = '0;
        upd_flag = 1'b1;
      end
      default: begin
        scr_code[s] = shade_code(int'($signed(r.lvl)));
        if (r.upd) upd_flag = 1'b1;
      end
    endcase
    rep.main_code = scr_code[0];
    rep.sub_code  = scr_code[1];
    rep.main_fade = fade_kind[0] != KIND_NONE;
    rep.sub_fade  = fade_kind[1] != KIND_NONE;
    rep.main_adj  = fade_lvl[0] != 0;
    rep.sub_adj   = fade_lvl[1] != 0;
    rep.upd       = upd_flag;
    return rep;
  endfunction

  function automatic int idle_gap();
    int n;
    n = 0;
    while (n < 50 && $urandom_range(99) < send_pct) n++;
    return n;
  endfunction

  function automatic fade_req_t random_request(input logic s);
    fade_req_t r;
    int pick;
    pick = $urandom_range(99);
    r.scr = s;
    r.ticks = ($urandom_range(99) < 60) ? ticks_t'($urandom_range(16))
                                        : ticks_t'($urandom_range(255));
    r.lvl = shade_t'($urandom_range(63));
    r.upd = 1'($urandom_range(1));
    if (pick < 30) r.cmd = CMD_TICK;
    else if (pick < 45) r.cmd = CMD_FADE_IN;
    else if (pick < 58) r.cmd = CMD_TO_BLACK;
    else if (pick < 71) r.cmd = CMD_TO_WHITE;
    else if (pick < 77) r.cmd = CMD_BLACK_OUT;
    else if (pick < 83) r.cmd = CMD_WHITE_OUT;
    else if (pick < 86) r.cmd = CMD_RESET;
    else r.cmd = CMD_SET_LEVEL;
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic offer(input fade_req_t r, input int gap, input logic typed,
                       input shade_report_t want);
    shade_report_t rep;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command        <= r.cmd;
    screen         <= r.scr;
    fade_ticks     <= r.ticks;
    level          <= r.lvl;
    request_update <= r.upd;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    rep = apply_command(r);
    pending_reports.push_back(typed ? want : rep);
    @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_200_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        hold_len--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : take_result
    shade_report_t got;
    shade_report_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{main_bright_code, sub_bright_code, main_fading, sub_fading,
              main_adjusted, sub_adjusted, update_requested};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("main_bright_code", want.main_code, got.main_code);
        compare_field("sub_bright_code", want.sub_code, got.sub_code);
        compare_field("main_fading", 16'(want.main_fade), 16'(got.main_fade));
        compare_field("sub_fading", 16'(want.sub_fade), 16'(got.sub_fade));
        compare_field("main_adjusted", 16'(want.main_adj), 16'(got.main_adj));
        compare_field("sub_adjusted", 16'(want.sub_adj), 16'(got.sub_adj));
        compare_field("update_requested", 16'(want.upd), 16'(got.upd));
      end
    end
  end

  initial begin
    fade_req_t r;
    fade_req_t t;
    int count;
    int burst;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_TICK;
    screen = 1'b0;
    fade_ticks = '0;
    level = '0;
    request_update = 1'b0;
    for (int s = 0; s < 2; s++) begin
      fade_lvl[s] = '0;
      fade_kind[s] = KIND_NONE;
      fade_step[s] = StepReset;
      tick_hold[s] = 1'b0;
      scr_code[s] = '0;
    end
    upd_flag = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) offer(script[i].req, 0, script[i].typed, script[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      // hold until every result is in
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_reports.size() != 0) @(posedge clk);
      send_pct = SendPct[ph];
      stall_pct = StallPct[ph];
      if (ph == 0) hold_len = 60;
      @(negedge clk);
      count = 0;
      while (count < 390) begin
        r = random_request(1'($urandom_range(1)));
        offer(r, idle_gap(), 1'b0, '0);
        count++;
        if (r.cmd inside {CMD_FADE_IN, CMD_TO_BLACK, CMD_TO_WHITE}) begin
          burst = $urandom_range(40);
          repeat (burst) begin
            t = random_request(($urandom_range(99) < 85) ? r.scr : ~r.scr);
            t.cmd = CMD_TICK;
            offer(t, idle_gap(), 1'b0, '0);
            count++;
          end
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
